### hdl/mt64_pkg.sv
// ----------------------------------------------------------------------------
// mt64_pkg: shared types and constants
// Constants, state encoding and the tempering function of the 64-bit
// Mersenne Twister generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mt64_pkg;

   localparam int STATE_WORDS   = 312;
   localparam int MIDDLE_OFFSET = 156;
   localparam int WORD_W        = 64;
   localparam int HALF_W        = WORD_W / 2;
   localparam int IDX_W         = $clog2(STATE_WORDS);
   localparam int UPPER_W       = 33;
   localparam int LOWER_W       = WORD_W - UPPER_W;

   localparam logic [WORD_W-1:0] SEED_RESET = 64'd5489;
   localparam logic [WORD_W-1:0] SEED_MULT  = 64'd6364136223846793005;
   localparam logic [WORD_W-1:0] TWIST_XOR  = 64'hB502_6F5A_A966_19E9;
   localparam logic [WORD_W-1:0] TEMPER_M0  = 64'h5555_5555_5555_5555;
   localparam logic [WORD_W-1:0] TEMPER_M1  = 64'h71D6_7FFF_EDA6_0000;
   localparam logic [WORD_W-1:0] TEMPER_M2  = 64'hFFF7_EEE0_0000_0000;

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
   localparam logic [IDX_W-1:0] MIDDLE_IDX = IDX_W'(MIDDLE_OFFSET);

   typedef enum logic [3:0] {
      ST_SEED_INIT,
      ST_SEED_M0,
      ST_SEED_M1,
      ST_SEED_M2,
      ST_SEED_WR,
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_CALC
   } state_type;

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] y;
      y = word;
      y = y ^ ((y >> 29) & TEMPER_M0);
      y = y ^ ((y << 17) & TEMPER_M1);
      y = y ^ ((y << 37) & TEMPER_M2);
      y = y ^ (y >> 43);
      return y;
   endfunction

endpackage

`default_nettype wire

### hdl/mt64_req_if.sv
// ----------------------------------------------------------------------------
// mt64_req_if: request channel
// Valid/ready channel that carries one draw request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mt64_req_if;
   logic valid;
   logic ready;
   logic reseed;

   modport source (output valid, output reseed, input ready);
   modport sink (input valid, input reseed, output ready);
endinterface

`default_nettype wire

### hdl/mt64_rsp_if.sv
// ----------------------------------------------------------------------------
// mt64_rsp_if: response channel
// Valid/ready channel that carries one tempered random word item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mt64_rsp_if;
   import mt64_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface

`default_nettype wire

### hdl/mersenne_twister_64_core.sv
// ----------------------------------------------------------------------------
// mersenne_twister_64_core: 64-bit Mersenne Twister generator
// Holds 312 state words in a single-write, single-read memory and returns one
// tempered word per request item, updating one state word per draw.
// ----------------------------------------------------------------------------
// A draw item is taken in the idle state, passes ST_RD0, ST_RD1, ST_RD2 and
// ST_CALC, and its result is registered in ST_CALC once the response register
// is free; no new item is taken until the block is back in idle. The pace is
// set by the single memory read port, which fetches the three state words of
// the incremental twist one after another. An item with reseed set first
// refills the state word by word; each word goes through a shared 32x32
// multiplier three times. The same seeding pass runs after reset, and
// req_ch.ready stays low until it is done. The seed register is written
// through csr_wr_en and csr_wr_data and takes effect at the next reseed.
`default_nettype none

module mersenne_twister_64_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [mt64_pkg::WORD_W-1:0] csr_wr_data,
   mt64_req_if.sink                        req_ch,
   mt64_rsp_if.source                      rsp_ch
);
   import mt64_pkg::*;

   logic [WORD_W-1:0] mem [STATE_WORDS];

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  seed_ff;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic               pending_ff, pending_in;
   logic [WORD_W-1:0]  prev_ff;
   logic [WORD_W-1:0]  prod_ff;
   logic [WORD_W-1:0]  acc_ff;
   logic [HALF_W-1:0]  cross_ff;
   logic [UPPER_W-1:0] yhi_ff;
   logic [LOWER_W-1:0] ylo_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;

   logic               req_fire;
   logic               calc_fire;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic [HALF_W-1:0]  mul_a, mul_b;
   logic [WORD_W-1:0]  seed_x;
   logic [WORD_W-1:0]  seed_word;
   logic [WORD_W-1:0]  twist_y;
   logic [WORD_W-1:0]  twist_word;
   logic [IDX_W-1:0]   ptr_next1;
   logic [IDX_W-1:0]   ptr_mid;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign calc_fire = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_ch.ready);

   assign ptr_next1 = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + IDX_W'(1);
   assign ptr_mid   = (ptr_ff >= MIDDLE_IDX) ? ptr_ff - MIDDLE_IDX : ptr_ff + MIDDLE_IDX;

   assign seed_x    = prev_ff ^ (prev_ff >> 62);
   assign seed_word = {acc_ff[WORD_W-1:HALF_W] + cross_ff + prod_ff[HALF_W-1:0],
                       acc_ff[HALF_W-1:0]};

   assign twist_y    = {yhi_ff, ylo_ff};
   assign twist_word = rd_data_ff ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

   // Next state.
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      unique case (state_ff)
         ST_SEED_INIT: state_in = ST_SEED_M0;
         ST_SEED_M0:   state_in = ST_SEED_M1;
         ST_SEED_M1:   state_in = ST_SEED_M2;
         ST_SEED_M2:   state_in = ST_SEED_WR;
         ST_SEED_WR: begin
            if (k_ff == LAST_IDX) begin
               state_in   = pending_ff ? ST_RD0 : ST_IDLE;
               pending_in = 1'b0;
            end else begin
               state_in = ST_SEED_M0;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.reseed) begin
                  state_in   = ST_SEED_INIT;
                  pending_in = 1'b1;
               end else begin
                  state_in = ST_RD0;
               end
            end
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: state_in = ST_RD2;
         ST_RD2: state_in = ST_CALC;
         ST_CALC: begin
            if (calc_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_SEED_INIT;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ch.ready = 1'b0;
      rd_addr      = ptr_ff;
      mem_we       = 1'b0;
      mem_waddr    = k_ff;
      mem_wdata    = seed_word;
      mul_a        = seed_x[HALF_W-1:0];
      mul_b        = SEED_MULT[HALF_W-1:0];
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      unique case (state_ff)
         ST_SEED_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = seed_ff;
            k_in      = IDX_W'(1);
         end
         ST_SEED_M0: ;
         ST_SEED_M1: mul_b = SEED_MULT[WORD_W-1:HALF_W];
         ST_SEED_M2: mul_a = seed_x[WORD_W-1:HALF_W];
         ST_SEED_WR: begin
            mem_we = 1'b1;
            k_in   = k_ff + IDX_W'(1);
            if (k_ff == LAST_IDX) begin
               ptr_in = '0;
            end
         end
         ST_IDLE: req_ch.ready = 1'b1;
         ST_RD0:  rd_addr = ptr_ff;
         ST_RD1:  rd_addr = ptr_next1;
         ST_RD2:  rd_addr = ptr_mid;
         ST_CALC: begin
            rd_addr   = ptr_mid;
            mem_waddr = ptr_ff;
            mem_wdata = twist_word;
            if (calc_fire) begin
               mem_we = 1'b1;
               ptr_in = ptr_next1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (calc_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED_INIT;
         pending_ff   <= 1'b0;
         seed_ff      <= SEED_RESET;
         ptr_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         ptr_ff       <= ptr_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= WORD_W'(mul_a) * WORD_W'(mul_b);
      if (state_ff == ST_SEED_INIT) begin
         prev_ff <= seed_ff;
      end else if (state_ff == ST_SEED_WR) begin
         prev_ff <= seed_word;
      end
      if (state_ff == ST_SEED_M1) begin
         acc_ff <= prod_ff + WORD_W'(k_ff);
      end
      if (state_ff == ST_SEED_M2) begin
         cross_ff <= prod_ff[HALF_W-1:0];
      end
      if (state_ff == ST_RD1) begin
         yhi_ff <= rd_data_ff[WORD_W-1:LOWER_W];
      end
      if (state_ff == ST_RD2) begin
         ylo_ff <= rd_data_ff[LOWER_W-1:0];
      end
      if (calc_fire) begin
         rsp_data_ff <= temper(twist_word);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.random_value = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/mt64_core_chk.sv
// ----------------------------------------------------------------------------
// mt64_core_chk: port checker
// Concurrent assertions on the ports of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mt64_core_chk (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [mt64_pkg::WORD_W-1:0] random_value
);

   // Reset always starts a seeding pass, so no item is taken right after it.
   a_seed_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted right after reset");

   // One item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(random_value))
      else $error("stalled response item changed");

endmodule

bind mersenne_twister_64_core mt64_core_chk u_mt64_core_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .random_value (rsp_ch.random_value)
);

`default_nettype wire
